// ----- rtl/sha_pkg.sv -----
// Shared types, constants and tables for the SHA-256 stream hash block.
// Used by sha_msg_buf, sha_core and sha256_stream_hash; no dependencies.
`timescale 1ns / 1ps

package sha_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD_MARK,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_LOAD,
      ST_ROUND,
      ST_ADD,
      ST_OUT
   } sha_state_type;

   // message buffer control
   typedef struct packed {
      logic       byte_shift;
      logic [7:0] byte_val;
      logic       round_shift;
   } sha_buf_ctl_type;

   // compression unit control
   typedef struct packed {
      logic       init;
      logic       load;
      logic       round;
      logic       add;
      logic [5:0] round_idx;
   } sha_core_ctl_type;

   localparam logic [5:0]  FILL_LAST  = 6'd63;
   localparam logic [5:0]  FILL_LEN   = 6'd56;
   localparam logic [7:0]  PAD_BYTE   = 8'h80;
   localparam logic [5:0]  ROUND_LAST = 6'd63;
   localparam logic [2:0]  WORD_LAST  = 3'd7;
   localparam logic [63:0] BYTE_BITS  = 64'd8;

   function automatic logic [31:0] sha_iv(input logic [2:0] idx);
      logic [31:0] r;
      case (idx)
         3'd0:    r = 32'h6a09e667;
         3'd1:    r = 32'hbb67ae85;
         3'd2:    r = 32'h3c6ef372;
         3'd3:    r = 32'ha54ff53a;
         3'd4:    r = 32'h510e527f;
         3'd5:    r = 32'h9b05688c;
         3'd6:    r = 32'h1f83d9ab;
         default: r = 32'h5be0cd19;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] sha_k(input logic [5:0] idx);
      logic [31:0] r;
      case (idx)
         6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
         6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
         6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
         6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
         6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
         6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
         6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
         6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
         6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
         6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
         6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
         6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
         6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
         6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
         6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
         6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
         6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
         6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
         6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
         6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
         6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
         6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
         6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
         6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
         6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
         6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
         6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
         6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
         6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
         6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
         6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
         6'd62: r = 32'hbef9a3f7;  default: r = 32'hc67178f2;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/sha_msg_buf.sv -----
// Message block buffer and schedule: a 16-word shift line filled a byte at a time,
// then stepped one word per round to produce W[t]. Depends on sha_pkg.
`timescale 1ns / 1ps

module sha_msg_buf (
   input  logic                     clock,
   input  logic                     reset,
   input  sha_pkg::sha_buf_ctl_type buf_ctl,
   output logic [31:0]              w_word
);

   logic [511:0] buf_ff;
   logic [511:0] buf_in;
   logic [31:0]  w1;
   logic [31:0]  w9;
   logic [31:0]  w14;
   logic [31:0]  sig0;
   logic [31:0]  sig1;
   logic [31:0]  w_next;

   // word 0 sits in the top bits, i.e. the first byte shifted in is the MSB
   assign w_word = buf_ff[511:480];
   assign w1     = buf_ff[479:448];
   assign w9     = buf_ff[223:192];
   assign w14    = buf_ff[63:32];

   always_comb begin
      sig0   = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ {3'b000, w1[31:3]};
      sig1   = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ {10'd0, w14[31:10]};
      w_next = sig1 + w9 + sig0 + w_word;
      buf_in = buf_ff;
      if (buf_ctl.byte_shift) begin
         buf_in = {buf_ff[503:0], buf_ctl.byte_val};
      end else if (buf_ctl.round_shift) begin
         buf_in = {buf_ff[479:0], w_next};
      end
   end

   // payload only; reset has no effect on the buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff <= buf_ff;
      end else begin
         buf_ff <= buf_in;
      end
   end

endmodule

// ----- rtl/sha_core.sv -----
// SHA-256 compression unit: chaining value, working variables and one shared
// round datapath stepped once per cycle while the round control is set. Depends on sha_pkg.
`timescale 1ns / 1ps

module sha_core (
   input  logic                      clock,
   input  logic                      reset,
   input  sha_pkg::sha_core_ctl_type core_ctl,
   input  logic [31:0]               w_word,
   input  logic [2:0]                rd_index,
   output logic [31:0]               rd_word
);

   logic [31:0] chain_ff [8];
   logic [31:0] chain_in [8];
   logic [31:0] v_ff [8];
   logic [31:0] v_in [8];
   logic [31:0] big0;
   logic [31:0] big1;
   logic [31:0] choose;
   logic [31:0] major;
   logic [31:0] t1;
   logic [31:0] t2;

   assign rd_word = chain_ff[rd_index];

   always_comb begin
      big1   = {v_ff[4][5:0], v_ff[4][31:6]} ^ {v_ff[4][10:0], v_ff[4][31:11]}
             ^ {v_ff[4][24:0], v_ff[4][31:25]};
      choose = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1     = v_ff[7] + big1 + choose + sha_pkg::sha_k(core_ctl.round_idx) + w_word;
      big0   = {v_ff[0][1:0], v_ff[0][31:2]} ^ {v_ff[0][12:0], v_ff[0][31:13]}
             ^ {v_ff[0][21:0], v_ff[0][31:22]};
      major  = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2     = big0 + major;

      for (int i = 0; i < 8; i++) begin
         v_in[i]     = v_ff[i];
         chain_in[i] = chain_ff[i];
      end

      if (core_ctl.load) begin
         for (int i = 0; i < 8; i++) begin
            v_in[i] = chain_ff[i];
         end
      end else if (core_ctl.round) begin
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
      end

      if (core_ctl.init) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = sha_pkg::sha_iv(3'(i));
         end
      end else if (core_ctl.add) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = chain_ff[i] + v_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= sha_pkg::sha_iv(3'(i));
         end
      end else begin
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= chain_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 8; i++) begin
         v_ff[i] <= v_in[i];
      end
   end

endmodule

// ----- rtl/sha256_stream_hash.sv -----
// SHA-256 over a byte stream: sequencer, length/fill counters, output register.
// Instantiates sha_msg_buf and sha_core; depends on sha_pkg.
// Sequence: a data byte is shifted into the buffer while idle; the 64th byte of a block
// starts a compression (load, 64 rounds of the shared round unit, chain add). An end
// marker starts padding: pad bytes up to offset 56 (0x80 mark included), a turnaround
// step and 8 length bytes, with a compression per full block (one or two), then eight
// digest transactions, one per cycle when rsp_tready is high.
// Reset (synchronous): sequencer idle, counters zero, chaining value at the initial hash.
`timescale 1ns / 1ps

module sha256_stream_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] msg_byte
   input  logic        req_tuser,   // [0] byte_present
   input  logic        req_tlast,   // msg_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
   output logic        rsp_tlast    // digest_last
);

   sha_pkg::sha_state_type    state_ff, state_in;
   sha_pkg::sha_state_type    ret_ff, ret_in;
   logic [5:0]                fill_ff, fill_in;
   logic [5:0]                round_ff, round_in;
   logic [63:0]               len_ff, len_in;
   logic [2:0]                out_idx_ff, out_idx_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [31:0]               word_ff, word_in;
   logic [2:0]                idx_ff, idx_in;
   logic                      last_ff, last_in;
   sha_pkg::sha_buf_ctl_type  buf_ctl;
   sha_pkg::sha_core_ctl_type core_ctl;
   logic [31:0]               w_word;
   logic [31:0]               rd_word;

   sha_msg_buf u_buf (
      .clock   (clock),
      .reset   (reset),
      .buf_ctl (buf_ctl),
      .w_word  (w_word)
   );

   sha_core u_core (
      .clock    (clock),
      .reset    (reset),
      .core_ctl (core_ctl),
      .w_word   (w_word),
      .rd_index (out_idx_ff),
      .rd_word  (rd_word)
   );

   assign req_tready = (state_ff == sha_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, idx_ff, word_ff};
   assign rsp_tlast  = last_ff;

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      fill_in      = fill_ff;
      round_in     = round_ff;
      len_in       = len_ff;
      out_idx_in   = out_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      word_in      = word_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      buf_ctl      = '0;
      core_ctl     = '0;
      core_ctl.round_idx = round_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         sha_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser) begin
                  buf_ctl.byte_shift = 1'b1;
                  buf_ctl.byte_val   = req_tdata;
                  fill_in            = fill_ff + 6'd1;
                  len_in             = len_ff + sha_pkg::BYTE_BITS;
               end
               if (req_tuser && fill_ff == sha_pkg::FILL_LAST) begin
                  state_in = sha_pkg::ST_LOAD;
                  ret_in   = req_tlast ? sha_pkg::ST_PAD_MARK : sha_pkg::ST_IDLE;
               end else if (req_tlast) begin
                  state_in = sha_pkg::ST_PAD_MARK;
               end
            end
         end
         sha_pkg::ST_PAD_MARK: begin
            buf_ctl.byte_shift = 1'b1;
            buf_ctl.byte_val   = sha_pkg::PAD_BYTE;
            fill_in            = fill_ff + 6'd1;
            state_in           = sha_pkg::ST_PAD_ZERO;
            if (fill_ff == sha_pkg::FILL_LAST) begin
               state_in = sha_pkg::ST_LOAD;
               ret_in   = sha_pkg::ST_PAD_ZERO;
            end
         end
         sha_pkg::ST_PAD_ZERO: begin
            if (fill_ff == sha_pkg::FILL_LEN) begin
               state_in = sha_pkg::ST_PAD_LEN;
            end else begin
               buf_ctl.byte_shift = 1'b1;
               buf_ctl.byte_val   = 8'h00;
               fill_in            = fill_ff + 6'd1;
               if (fill_ff == sha_pkg::FILL_LAST) begin
                  state_in = sha_pkg::ST_LOAD;
                  ret_in   = sha_pkg::ST_PAD_ZERO;
               end
            end
         end
         sha_pkg::ST_PAD_LEN: begin
            // big-endian bit length, top byte first
            buf_ctl.byte_shift = 1'b1;
            buf_ctl.byte_val   = len_ff[63:56];
            len_in             = {len_ff[55:0], 8'h00};
            fill_in            = fill_ff + 6'd1;
            if (fill_ff == sha_pkg::FILL_LAST) begin
               state_in = sha_pkg::ST_LOAD;
               ret_in   = sha_pkg::ST_OUT;
            end
         end
         sha_pkg::ST_LOAD: begin
            core_ctl.load = 1'b1;
            round_in      = 6'd0;
            state_in      = sha_pkg::ST_ROUND;
         end
         sha_pkg::ST_ROUND: begin
            core_ctl.round      = 1'b1;
            buf_ctl.round_shift = 1'b1;
            round_in            = round_ff + 6'd1;
            if (round_ff == sha_pkg::ROUND_LAST) begin
               state_in = sha_pkg::ST_ADD;
            end
         end
         sha_pkg::ST_ADD: begin
            core_ctl.add = 1'b1;
            state_in     = ret_ff;
         end
         sha_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               word_in      = rd_word;
               idx_in       = out_idx_ff;
               last_in      = (out_idx_ff == sha_pkg::WORD_LAST);
               out_idx_in   = out_idx_ff + 3'd1;
               if (out_idx_ff == sha_pkg::WORD_LAST) begin
                  // last word captured; restart for the next message
                  core_ctl.init = 1'b1;
                  len_in        = 64'd0;
                  state_in      = sha_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = sha_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sha_pkg::ST_IDLE;
         ret_ff       <= sha_pkg::ST_IDLE;
         fill_ff      <= 6'd0;
         round_ff     <= 6'd0;
         len_ff       <= 64'd0;
         out_idx_ff   <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         fill_ff      <= fill_in;
         round_ff     <= round_in;
         len_ff       <= len_in;
         out_idx_ff   <= out_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      idx_ff  <= idx_in;
      last_ff <= last_in;
   end

endmodule
